>>> rtl/idl_pkg.sv
package idl_pkg;

	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [3:0] ID_LAST   = 4'd10;
	localparam logic [3:0] HYPHEN_AT = 4'd6;
	localparam logic [3:0] POS_MAX   = 4'd15;

	typedef enum logic [2:0] {
		ST_VALID    = 3'd0,
		ST_FORMAT   = 3'd1,
		ST_MONTH    = 3'd2,
		ST_FEB29    = 3'd3,
		ST_FEB_DAY  = 3'd4,
		ST_DAY30    = 3'd5,
		ST_DAY31    = 3'd6,
		ST_MISMATCH = 3'd7
	} idl_status_t;

	typedef struct packed {
		logic [3:0] pos;
		logic [6:0] luhn_sum;
		logic [6:0] year;
		logic [6:0] month;
		logic [6:0] day;
		logic [3:0] entered;
		logic       format_bad;
	} idl_state_t;

	// digit after optional Luhn doubling, folded back to one digit
	function automatic logic [3:0] luhn_term(input logic [3:0] dv, input logic dbl);
		logic [4:0] t;
		t = dbl ? {dv, 1'b0} : {1'b0, dv};
		if (t >= 5'd10)
			t = t - 5'd9;
		return t[3:0];
	endfunction

	function automatic logic [3:0] mod10(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (r >= 7'd80) r = r - 7'd80;
		if (r >= 7'd40) r = r - 7'd40;
		if (r >= 7'd20) r = r - 7'd20;
		if (r >= 7'd10) r = r - 7'd10;
		return r[3:0];
	endfunction

	function automatic logic [6:0] times10_add(input logic [6:0] v, input logic [3:0] dv);
		return (v << 3) + (v << 1) + {3'b000, dv};
	endfunction

endpackage

>>> rtl/idl_track.sv
module idl_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	input  logic              last,
	output idl_pkg::idl_state_t upd
);
	import idl_pkg::*;

	idl_state_t state_q;
	idl_state_t nxt;
	logic       is_digit;
	logic [3:0] dv;
	logic [3:0] pos;
	logic       dbl;

	assign pos      = state_q.pos;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_ZERO + 8'd9);
	assign dv       = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
	// even Luhn index is doubled; the hyphen does not count
	assign dbl      = (pos < HYPHEN_AT) ? ~pos[0] : pos[0];

	always_comb begin
		upd = state_q;
		if (pos > ID_LAST) begin
			upd.format_bad = 1'b1;
		end else if (pos == HYPHEN_AT) begin
			if (ch != CH_HYPHEN)
				upd.format_bad = 1'b1;
		end else if (!is_digit) begin
			upd.format_bad = 1'b1;
		end else begin
			if (pos < 4'd2)
				upd.year = times10_add(state_q.year, dv);
			else if (pos < 4'd4)
				upd.month = times10_add(state_q.month, dv);
			else if (pos < 4'd6)
				upd.day = times10_add(state_q.day, dv);
			if (pos < ID_LAST)
				upd.luhn_sum = state_q.luhn_sum + {3'b000, luhn_term(dv, dbl)};
			else
				upd.entered = dv;
		end
	end

	// position saturates at the top of its range
	always_comb begin
		nxt     = upd;
		nxt.pos = (pos < POS_MAX) ? pos + 4'd1 : pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			if (last) begin
				state_q <= '0;
			end else begin
				state_q <= nxt;
			end
		end
	end

endmodule

>>> rtl/idl_verdict.sv
module idl_verdict (
	input  idl_pkg::idl_state_t  upd,
	output idl_pkg::idl_status_t status,
	output logic [3:0]           check_digit
);
	import idl_pkg::*;

	logic [3:0]  rem;
	logic [3:0]  chk;
	logic        leap;
	idl_status_t date_st;

	assign rem  = mod10(upd.luhn_sum);
	assign chk  = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;
	// two-digit year: zero counts as a leap year by the 400 rule
	assign leap = (upd.year[1:0] == 2'b00) && (upd.year != 7'd100);

	always_comb begin
		date_st = ST_VALID;
		if (upd.month < 7'd1 || upd.month > 7'd12) begin
			date_st = ST_MONTH;
		end else if (upd.month == 7'd2) begin
			if (upd.day == 7'd29)
				date_st = leap ? ST_VALID : ST_FEB29;
			else if (upd.day < 7'd1 || upd.day > 7'd28)
				date_st = ST_FEB_DAY;
		end else if (upd.month == 7'd4 || upd.month == 7'd6 ||
				upd.month == 7'd9 || upd.month == 7'd11) begin
			if (upd.day < 7'd1 || upd.day > 7'd30)
				date_st = ST_DAY30;
		end else if (upd.day < 7'd1 || upd.day > 7'd31) begin
			date_st = ST_DAY31;
		end
	end

	always_comb begin
		if (upd.format_bad || upd.pos != ID_LAST) begin
			status      = ST_FORMAT;
			check_digit = 4'd0;
		end else begin
			check_digit = chk;
			if (date_st == ST_VALID && upd.entered != chk)
				status = ST_MISMATCH;
			else
				status = date_st;
		end
	end

endmodule

>>> rtl/id_number_luhn_validator.sv
// Checks an ID string of the form YYMMDD-nnnC, one ASCII character per
// transaction on the slave side with tlast on the final character. Each
// character first sits in an input register; a short update of position,
// date fields and Luhn sum follows, and on the tlast character
// one verdict (status and computed control digit) lands in the output
// register. Characters without tlast produce no output. Status: 0 valid,
// 1 format, 2 month, 3 Feb 29 in non-leap year, 4 February day, 5 day in a
// 30-day month, 6 day in a 31-day month, 7 control digit mismatch. A new
// character is taken every cycle; only a tlast character waiting on a full,
// stalled output register holds the input back.
module id_number_luhn_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [2:0] status, [6:3] check_digit, [7] zero
);
	import idl_pkg::*;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;
	logic        advance;
	logic        m_tvalid_q;
	logic [6:0]  result_q;
	idl_state_t  upd;
	idl_status_t status;
	logic [3:0]  check_digit;

	assign advance  = valid_s1 && (!last_s1 || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	idl_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.last   (last_s1),
		.upd    (upd)
	);

	idl_verdict u_verdict (
		.upd         (upd),
		.status      (status),
		.check_digit (check_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			result_q <= {check_digit, status};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, result_q};

endmodule

>>> rtl/idl_checker.sv
module idl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	import idl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == 1'b0)
		else $error("tdata padding bit set");

	a_fmt_chk: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_FORMAT |-> m_tdata[6:3] == 4'd0)
		else $error("format error with nonzero control digit");

	a_chk_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:3] <= 4'd9)
		else $error("control digit out of range");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind id_number_luhn_validator idl_checker u_idl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
